FILE: hw/rtl/sorted_list_engine_assert.svh
// Assertion macros shared by the sorted list engine RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define SLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list engine: same-cycle check failed");

// next-cycle implication
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list engine: next-cycle check failed");

`endif

FILE: hw/rtl/sle_pkg.sv
// Shared types and constants of the sorted list engine.
// No dependencies; imported by sle_ctrl, sle_dp and the top level.
package sle_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 31;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UNIQUE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_W-1:0]  result_value;
        logic [INDEX_W-1:0]  result_index;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic run;
        logic emit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;
    } t_dp_stat;

endpackage

FILE: hw/rtl/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; no shared types used.
module sle_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/sle_ctrl.sv
// Controller of the sorted list engine: command sequencing and output handshake.
// Depends on sle_pkg for the command and status structs.
module sle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sle_pkg::t_dp_stat i_stat,
    output sle_pkg::t_dp_cmd  o_cmd
);
    import sle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    t_dp_cmd     cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        cmd         = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                cmd.run = 1'b1;
                if (i_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // result word parks here until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    cmd.emit    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

FILE: hw/rtl/sle_dp.sv
// Datapath of the sorted list engine: entry RAM, scan pointers, compare and result.
// Depends on sle_pkg, sle_ram and sorted_list_engine_assert.svh.
`include "sorted_list_engine_assert.svh"

module sle_dp #(
    parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sle_pkg::t_in_word  i_in_word,
    input  sle_pkg::t_dp_cmd   i_cmd,
    output sle_pkg::t_dp_stat  o_stat,
    output sle_pkg::t_out_word o_out_word
);
    import sle_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CW-1:0]       r_count, n_count;
    logic [CMD_W-1:0]    r_op, n_op;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic                r_err, n_err;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_left, n_left;
    logic [CW-1:0]       r_base, n_base;
    logic                r_pend, n_pend;
    logic [CW-1:0]       r_pend_pos, n_pend_pos;
    logic [CW-1:0]       r_w, n_w;
    logic [VALUE_W-1:0]  r_last, n_last;
    logic [VALUE_W-1:0]  r_rv, n_rv;
    logic [INDEX_W-1:0]  r_ri, n_ri;
    logic [STATUS_W-1:0] r_st, n_st;
    t_out_word           r_out, n_out;

    logic               issue;
    logic               stop;
    logic               done;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;

    sle_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_count    = r_count;
        n_op       = r_op;
        n_value    = r_value;
        n_err      = r_err;
        n_pos      = r_pos;
        n_left     = r_left;
        n_base     = r_base;
        n_pend     = r_pend;
        n_pend_pos = r_pend_pos;
        n_w        = r_w;
        n_last     = r_last;
        n_rv       = r_rv;
        n_ri       = r_ri;
        n_st       = r_st;
        n_out      = r_out;
        issue      = 1'b0;
        stop       = 1'b0;
        done       = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_value;
        rd_en      = 1'b0;
        rd_addr    = r_pos[AW-1:0];

        if (i_cmd.load) begin
            n_op    = i_in_word.command;
            n_value = i_in_word.value;
            n_err   = 1'b0;
            n_pend  = 1'b0;
            n_w     = '0;
            n_rv    = '0;
            n_ri    = '0;
            n_st    = ST_OK;
            n_pos   = '0;
            n_base  = '0;
            n_left  = r_count;
            unique case (i_in_word.command)
                CMD_PUSH: begin
                    // walk down from the top entry, shifting larger ones up
                    n_pos = r_count - 1'b1;
                    if (r_count == CW'(CAPACITY)) begin
                        n_err  = 1'b1;
                        n_st   = ST_FULL;
                        n_left = '0;
                    end
                end
                CMD_POP: begin
                    if (r_count == '0) begin
                        n_err = 1'b1;
                        n_st  = ST_EMPTY;
                    end
                end
                CMD_ERASE: begin
                    if (CMPW'(i_in_word.index) >= CMPW'(r_count)) begin
                        n_err  = 1'b1;
                        n_st   = ST_BAD_INDEX;
                        n_left = '0;
                    end else begin
                        n_pos  = CW'(i_in_word.index);
                        n_base = CW'(i_in_word.index);
                        n_left = r_count - CW'(i_in_word.index);
                    end
                end
                CMD_FIND, CMD_REMOVE, CMD_UNIQUE: begin
                end
                default: begin
                    n_left = '0;
                end
            endcase
        end

        if (i_cmd.run) begin
            issue      = (r_left != '0);
            rd_en      = issue;
            n_pend     = issue;
            n_pend_pos = r_pos;
            if (issue) begin
                n_left = r_left - 1'b1;
                n_pos  = (r_op == CMD_PUSH) ? r_pos - 1'b1 : r_pos + 1'b1;
            end

            // entry read last cycle: rd_data holds entry r_pend_pos
            if (r_pend) begin
                unique case (r_op)
                    CMD_PUSH: begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_pend_pos + 1'b1);
                        if (rd_data > r_value) begin
                            wr_data = rd_data;
                        end else begin
                            wr_data = r_value;
                            stop    = 1'b1;
                        end
                    end
                    CMD_POP, CMD_ERASE: begin
                        if (r_pend_pos == r_base) begin
                            n_rv = rd_data;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_pend_pos - 1'b1);
                            wr_data = rd_data;
                        end
                    end
                    CMD_FIND: begin
                        if (rd_data == r_value) begin
                            n_ri = INDEX_W'(r_pend_pos);
                            stop = 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (rd_data != r_value) begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_w);
                            wr_data = rd_data;
                            n_w     = r_w + 1'b1;
                        end
                    end
                    CMD_UNIQUE: begin
                        if (r_pend_pos == '0) begin
                            n_last = rd_data;
                            n_w    = CW'(1);
                        end else if (rd_data != r_last) begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_w);
                            wr_data = rd_data;
                            n_w     = r_w + 1'b1;
                            n_last  = rd_data;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            done = stop || (!issue && !r_pend);

            if (done) begin
                n_pend = 1'b0;
                if (!r_err) begin
                    unique case (r_op)
                        CMD_PUSH: begin
                            n_count = r_count + 1'b1;
                            // scan ran off the bottom: new value is the smallest
                            if (!stop) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = r_value;
                            end
                        end
                        CMD_POP, CMD_ERASE: begin
                            n_count = r_count - 1'b1;
                        end
                        CMD_FIND: begin
                            if (!stop) begin
                                n_st = ST_NOT_FOUND;
                            end
                        end
                        CMD_REMOVE: begin
                            n_count = r_w;
                            if (r_w == r_count) begin
                                n_st = ST_NOT_FOUND;
                            end
                        end
                        CMD_UNIQUE: begin
                            n_count = r_w;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        if (i_cmd.emit) begin
            n_out.result_value = r_rv;
            n_out.result_index = r_ri;
            n_out.entry_count  = COUNT_W'(r_count);
            n_out.status       = r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_value    <= n_value;
        r_pos      <= n_pos;
        r_left     <= n_left;
        r_base     <= n_base;
        r_pend_pos <= n_pend_pos;
        r_w        <= n_w;
        r_last     <= n_last;
        r_rv       <= n_rv;
        r_ri       <= n_ri;
        r_st       <= n_st;
        r_out      <= n_out;
    end

    assign o_stat.done = done;
    assign o_out_word  = r_out;

    `SLE_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `SLE_ASSERT_IMPL(a_rd_stored, i_clk, i_rst_n, i_cmd.run && r_pend && !r_err, r_pend_pos < r_count)
    `SLE_ASSERT_IMPL(a_wr_range, i_clk, i_rst_n, wr_en, CW'(wr_addr) <= r_count)
    `SLE_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !(i_cmd.run && done), $stable(r_count))

endmodule

FILE: hw/rtl/sorted_list_engine.sv
// Top level of the sorted list engine: controller plus datapath.
// Depends on sle_pkg, sle_ctrl, sle_dp (which holds sle_ram).
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
//   out     | output    | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//
// Entries walked per command: the whole list for pop/remove/unique, those up
// to the first match for find (all if none), count - index for erase, and for
// push those from the top down to the first not larger than the new value;
// errors, unused codes and an empty list walk none.
// The walk runs at one entry per cycle through the single read port of the RAM.
// No clearing pass after reset: the count alone marks valid entries.
// A new word is taken while a result waits; a stalled output parks the
// controller in S_DONE until the output register frees up.
module sorted_list_engine #(
    parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sle_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sle_pkg::t_out_word o_out_word
);
    import sle_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    sle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_word (o_out_word)
    );

endmodule
